[design/cle_pkg.sv]
// Shared constants and types for the console line editor.
`timescale 1ns / 1ps
package cle_pkg;

  localparam int BUFFER_DEPTH = 128;
  localparam int PTR_SPAN     = 2 * BUFFER_DEPTH;
  localparam int PTR_W        = $clog2(PTR_SPAN);
  localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
  localparam int CHAR_W       = 8;
  localparam int KIND_W       = 2;
  localparam int ERASE_W      = 8;
  localparam int ERASE_MAX    = (1 << ERASE_W) - 1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [KIND_W-1:0] kind_t;

  // result kinds
  localparam kind_t KIND_ECHO  = 2'd0;
  localparam kind_t KIND_ERASE = 2'd1;
  localparam kind_t KIND_DATA  = 2'd2;
  localparam kind_t KIND_EMPTY = 2'd3;

  // request function
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // control characters
  localparam char_t KEY_NUL  = 8'h00;
  localparam char_t KEY_EOF  = 8'h04;
  localparam char_t KEY_BS   = 8'h08;
  localparam char_t KEY_NL   = 8'h0A;
  localparam char_t KEY_CR   = 8'h0D;
  localparam char_t KEY_KILL = 8'h15;
  localparam char_t KEY_DEL  = 8'h7F;

  typedef struct packed {
    logic load_item;
    logic apply;
    logic apply_read;
  } cle_cmd_t;

  typedef struct packed {
    logic has_result;
    logic need_read;
    logic out_free;
  } cle_status_t;

endpackage

[design/cle_if.sv]
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface cle_in_if;
  import cle_pkg::*;
  logic  valid;
  logic  ready;
  logic  func;
  char_t char_in;

  modport source (output valid, output func, output char_in, input ready);
  modport sink (input valid, input func, input char_in, output ready);
endinterface

interface cle_out_if;
  import cle_pkg::*;
  logic               valid;
  logic               ready;
  kind_t              kind;
  char_t              data;
  logic [ERASE_W-1:0] erase_count;
  logic               line_committed;

  modport source (output valid, output kind, output data, output erase_count,
                  output line_committed, input ready);
  modport sink (input valid, input kind, input data, input erase_count,
                input line_committed, output ready);
endinterface

[design/cle_ctrl.sv]
// Sequencer: accepts a request, runs it through the datapath, retires it.
`timescale 1ns / 1ps
module cle_ctrl
  import cle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cle_status_t status_i,
  output cle_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.need_read) begin
          state_d = ST_READ;
        end else if (!status_i.has_result) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_READ: begin
        // store read data is registered; wait for room in the output stage
        if (status_i.out_free) begin
          cmd_o.apply_read = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/cle_dp.sv]
// Datapath: line store, edit/commit/read pointers, decode and result register.
`timescale 1ns / 1ps
module cle_dp
  import cle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        func_i,
  input  char_t       char_in_i,
  input  cle_cmd_t    cmd_i,
  output cle_status_t status_o,
  cle_out_if.source   out_o
);

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(PTR_SPAN - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? PTR_W'(PTR_SPAN - 1) : p - 1'b1;
  endfunction

  function automatic ptr_t ptr_dist(ptr_t a, ptr_t b);
    return (a >= b) ? a - b : PTR_W'(int'(a) + PTR_SPAN - int'(b));
  endfunction

  function automatic slot_t slot_of(ptr_t p);
    return (p >= PTR_W'(BUFFER_DEPTH)) ? SLOT_W'(p - PTR_W'(BUFFER_DEPTH)) : SLOT_W'(p);
  endfunction

  function automatic logic [ERASE_W-1:0] sat_erase(ptr_t n);
    return (int'(n) > ERASE_MAX) ? ERASE_W'(ERASE_MAX) : ERASE_W'(n);
  endfunction

  char_t mem [BUFFER_DEPTH];
  char_t rd_data_q;

  logic  cr_to_newline_q;
  logic  func_q;
  char_t char_q;
  ptr_t  edit_q, edit_d;
  ptr_t  commit_q, commit_d;
  ptr_t  read_q;

  logic               out_valid_q;
  kind_t              out_kind_q;
  char_t              out_data_q;
  logic [ERASE_W-1:0] out_erase_q;
  logic               out_commit_q;

  logic               has_result, need_read, wr_en;
  kind_t              res_kind;
  char_t              res_data, wr_data;
  logic [ERASE_W-1:0] res_erase;
  logic               res_commit;
  ptr_t               kill_dist, edit_inc;

  assign kill_dist = ptr_dist(edit_q, commit_q);
  assign edit_inc  = ptr_inc(edit_q);

  always_comb begin
    has_result = 1'b0;
    need_read  = 1'b0;
    wr_en      = 1'b0;
    wr_data    = char_q;
    res_kind   = KIND_ECHO;
    res_data   = '0;
    res_erase  = '0;
    res_commit = 1'b0;
    edit_d     = edit_q;
    commit_d   = commit_q;
    if (func_q == FUNC_READ) begin
      if (read_q == commit_q) begin
        has_result = 1'b1;
        res_kind   = KIND_EMPTY;
      end else begin
        need_read = 1'b1;
      end
    end else begin
      unique case (char_q) inside
        KEY_KILL: begin
          if (kill_dist != '0) begin
            has_result = 1'b1;
            res_kind   = KIND_ERASE;
            res_erase  = sat_erase(kill_dist);
            edit_d     = commit_q;
          end
        end
        KEY_BS, KEY_DEL: begin
          if (edit_q != commit_q) begin
            has_result = 1'b1;
            res_kind   = KIND_ERASE;
            res_erase  = ERASE_W'(1);
            edit_d     = ptr_dec(edit_q);
          end
        end
        default: begin
          // drop NUL, anything on a full buffer, and CR when not mapped
          if (char_q != KEY_NUL
              && ptr_dist(edit_q, read_q) < PTR_W'(BUFFER_DEPTH)
              && !(char_q == KEY_CR && !cr_to_newline_q)) begin
            has_result = 1'b1;
            wr_en      = 1'b1;
            wr_data    = (char_q == KEY_CR) ? KEY_NL : char_q;
            res_kind   = KIND_ECHO;
            res_data   = wr_data;
            edit_d     = edit_inc;
            if (wr_data == KEY_NL || wr_data == KEY_EOF
                || ptr_dist(edit_inc, read_q) == PTR_W'(BUFFER_DEPTH)) begin
              res_commit = 1'b1;
              commit_d   = edit_inc;
            end
          end
        end
      endcase
    end
  end

  assign status_o.has_result = has_result;
  assign status_o.need_read  = need_read;
  assign status_o.out_free   = !out_valid_q || out_o.ready;

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && wr_en) begin
      mem[slot_of(edit_q)] <= wr_data;
    end
    rd_data_q <= mem[slot_of(read_q)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_i;
      char_q <= char_in_i;
    end
    if (cmd_i.apply) begin
      out_kind_q   <= res_kind;
      out_data_q   <= res_data;
      out_erase_q  <= res_erase;
      out_commit_q <= res_commit;
    end else if (cmd_i.apply_read) begin
      out_kind_q   <= KIND_DATA;
      out_data_q   <= rd_data_q;
      out_erase_q  <= '0;
      out_commit_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_to_newline_q <= 1'b1;
      edit_q          <= '0;
      commit_q        <= '0;
      read_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cr_to_newline_q <= cfg_wdata_i;
      end
      if (cmd_i.apply) begin
        edit_q   <= edit_d;
        commit_q <= commit_d;
      end
      if (cmd_i.apply_read) begin
        read_q <= ptr_inc(read_q);
      end
      if (cmd_i.apply || cmd_i.apply_read) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_kind_q;
  assign out_o.data           = out_data_q;
  assign out_o.erase_count    = out_erase_q;
  assign out_o.line_committed = out_commit_q;

endmodule

[design/console_line_editor_unit.sv]
// Top level of the console line editor.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        func, char_in
//   out_o    out  valid/ready        kind, data, erase_count, line_committed
//   cfg      in   cfg_we_i, no wait  cfg_wdata_i = cr_to_newline
//
// A character transaction and a read that finds nothing pass through accept and
// execute; a read that returns data also takes a read step for the registered
// read port of the line store.
// Reset clears the pointers and sets cr_to_newline; store contents stay
// undefined and need no clearing pass. A result waits in the output register
// while the next transaction is accepted; its execution stalls only if it
// has a result and the output register is still full.
`timescale 1ns / 1ps
module console_line_editor_unit
  import cle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  cle_in_if.sink    in_i,
  cle_out_if.source out_o
);

  cle_cmd_t    cmd;
  cle_status_t status;
  logic        in_ready;

  assign in_i.ready = in_ready;

  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (in_i.func),
    .char_in_i   (in_i.char_in),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule

[design/cle_checker.sv]
// Port-level checks for the console line editor, bound to the top level.
`timescale 1ns / 1ps
module cle_checker
  import cle_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_func_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input kind_t              out_kind_i,
  input char_t              out_data_i,
  input logic [ERASE_W-1:0] out_erase_count_i,
  input logic               out_line_committed_i
);

  // one transaction in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted back to back");

  // a read into an empty output stage answers with an empty or a data result
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i == FUNC_READ && !out_valid_i
    |-> ##[2:3] (out_valid_i && (out_kind_i == KIND_DATA || out_kind_i == KIND_EMPTY)))
    else $error("read request did not answer in time");

  // only an echo can commit a line
  a_commit_on_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_ECHO |-> !out_line_committed_i)
    else $error("commit flag on a non-echo result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
    && $stable(out_data_i) && $stable(out_erase_count_i))
    else $error("stalled result changed");

endmodule

bind console_line_editor_unit cle_checker u_cle_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .in_func_i            (in_i.func),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_kind_i           (out_o.kind),
  .out_data_i           (out_o.data),
  .out_erase_count_i    (out_o.erase_count),
  .out_line_committed_i (out_o.line_committed)
);

[test/cle_line_checker.sv]
`timescale 1ns / 1ps
// Line editor checker: tracks editor state, predicts each result and compares it.
module cle_line_checker
  import cle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  cle_in_if    in_mon_i,
  cle_out_if   out_mon_i,
  output int   mismatch_o,
  output int   outstanding_o
);

  typedef struct packed {
    kind_t              kind;
    char_t              data;
    logic [ERASE_W-1:0] erase_count;
    logic               line_committed;
  } term_out_t;

  char_t     line_mem [BUFFER_DEPTH];
  ptr_t      ed_ptr;
  ptr_t      cm_ptr;
  ptr_t      rd_ptr;
  logic      cr_mode;
  term_out_t term_out_q [$];
  int        errors = 0;

  task automatic log_error(input string what, input term_out_t want, input term_out_t got);
    if (errors < 10) begin
      $display("%0t %s: exp kind %0d data %h erase %0d commit %b, got %0d %h %0d %b",
               $time, what, want.kind, want.data, want.erase_count, want.line_committed,
               got.kind, got.data, got.erase_count, got.line_committed);
    end
    errors++;
  endtask

  // Applies one accepted request to the tracked state; queues its result, if any.
  task automatic apply_request(input logic func, input char_t key);
    char_t     c;
    ptr_t      span;
    term_out_t r;
    c = key;
    r = '0;
    if (func == FUNC_READ) begin
      if (rd_ptr == cm_ptr) begin
        r.kind = KIND_EMPTY;
      end else begin
        r.kind = KIND_DATA;
        r.data = line_mem[slot_t'(rd_ptr)];
        rd_ptr = rd_ptr + 1'b1;
      end
      term_out_q.push_back(r);
    end else if (c == KEY_KILL) begin
      span = ed_ptr - cm_ptr;
      if (span != '0) begin
        ed_ptr = cm_ptr;
        r.kind = KIND_ERASE;
        r.erase_count = (int'(span) > ERASE_MAX) ? ERASE_W'(ERASE_MAX) : ERASE_W'(span);
        term_out_q.push_back(r);
      end
    end else if (c == KEY_BS || c == KEY_DEL) begin
      if (ed_ptr != cm_ptr) begin
        ed_ptr = ed_ptr - 1'b1;
        r.kind = KIND_ERASE;
        r.erase_count = ERASE_W'(1);
        term_out_q.push_back(r);
      end
    end else begin
      span = ed_ptr - rd_ptr;
      // zero bytes, a full buffer and dropped carriage returns leave no trace
      if (c != KEY_NUL && int'(span) < BUFFER_DEPTH && !(c == KEY_CR && !cr_mode)) begin
        if (c == KEY_CR) begin
          c = KEY_NL;
        end
        line_mem[slot_t'(ed_ptr)] = c;
        ed_ptr = ed_ptr + 1'b1;
        span = ed_ptr - rd_ptr;
        r.kind = KIND_ECHO;
        r.data = c;
        if (c == KEY_NL || c == KEY_EOF || int'(span) == BUFFER_DEPTH) begin
          cm_ptr = ed_ptr;
          r.line_committed = 1'b1;
        end
        term_out_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    term_out_t got;
    term_out_t want;
    if (!rst_ni) begin
      ed_ptr = '0;
      cm_ptr = '0;
      rd_ptr = '0;
      cr_mode = 1'b1;
      line_mem = '{default: '0};
      term_out_q.delete();
      outstanding_o <= 0;
      mismatch_o <= errors;
    end else begin
      if (cfg_we_i) begin
        cr_mode = cfg_wdata_i;
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.kind = out_mon_i.kind;
        got.data = out_mon_i.data;
        got.erase_count = out_mon_i.erase_count;
        got.line_committed = out_mon_i.line_committed;
        if (term_out_q.size() == 0) begin
          log_error("result with none pending", '0, got);
        end else begin
          want = term_out_q.pop_front();
          if (got.kind != want.kind || got.data != want.data ||
              got.erase_count != want.erase_count ||
              got.line_committed != want.line_committed) begin
            log_error("wrong result", want, got);
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        apply_request(in_mon_i.func, in_mon_i.char_in);
      end
      outstanding_o <= term_out_q.size();
      mismatch_o <= errors;
    end
  end

endmodule

[test/console_line_editor_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the console line editor: stimulus, sink pacing, watchdog, verdict.
module console_line_editor_unit_tb;
  import cle_pkg::*;

  typedef enum int { MIX_EDIT, MIX_FILL, MIX_RAW } key_mix_e;
  typedef enum int { PACE_OPEN, PACE_COIN, PACE_MOSTLY, PACE_SPARSE } sink_pace_e;

  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_wdata;
  int         mismatch_count;
  int         pending_results;
  int         quiet_cycles = 0;
  int         burst_left = 0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  int         span_left = 0;
  sink_pace_e sink_pace = PACE_OPEN;

  cle_in_if  req_ch();
  cle_out_if rsp_ch();

  console_line_editor_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (req_ch),
    .out_o      (rsp_ch)
  );

  cle_line_checker line_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon_i     (req_ch),
    .out_mon_i    (rsp_ch),
    .mismatch_o   (mismatch_count),
    .outstanding_o(pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random pacing stretches, plus long hold-offs on request.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (span_left == 0) begin
          sink_pace = sink_pace_e'($urandom_range(0, 3));
          span_left = $urandom_range(1, 40);
        end
        span_left--;
        case (sink_pace)
          PACE_OPEN:   rsp_ch.ready <= 1'b1;
          PACE_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
          PACE_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          default:     rsp_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic char_t next_key(input key_mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_RAW:  return char_t'($urandom_range(0, 255));
      MIX_FILL: return (r < 8) ? KEY_BS : char_t'($urandom_range(8'h20, 8'h7E));
      default: begin
        if (r < 8)  return KEY_NL;
        if (r < 12) return KEY_CR;
        if (r < 15) return KEY_EOF;
        if (r < 22) return KEY_BS;
        if (r < 26) return KEY_DEL;
        if (r < 29) return KEY_KILL;
        if (r < 31) return KEY_NUL;
        if (r < 50) return char_t'($urandom_range(0, 255));
        return char_t'($urandom_range(8'h20, 8'h7E));
      end
    endcase
  endfunction

  // Offers one transaction; bursts of random length with random gaps between.
  task automatic send_key(input logic func, input char_t key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.func <= func;
    req_ch.char_in <= key;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Stop offering, wait for every pending result, then let the pipe drain.
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cr_mode(input logic mode);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int read_pct, input logic cr_mode,
                           input key_mix_e mix, input bit with_hold);
    logic is_read;
    write_cr_mode(cr_mode);
    if (with_hold) begin
      hold_requests++;
    end
    repeat (count) begin
      is_read = ($urandom_range(1, 100) <= read_pct);
      if (is_read) begin
        send_key(FUNC_READ, char_t'($urandom_range(0, 255)));
      end else begin
        send_key(FUNC_CHAR, next_key(mix));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_CHAR;
    req_ch.char_in = KEY_NUL;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty line: read, erase and kill have nothing to act on; zero byte ignored
    send_key(FUNC_READ, 8'hFF);
    send_key(FUNC_CHAR, KEY_BS);
    send_key(FUNC_CHAR, KEY_KILL);
    send_key(FUNC_CHAR, KEY_NUL);
    // single erases, then kill of a partial line
    send_key(FUNC_CHAR, 8'h61);
    send_key(FUNC_CHAR, 8'h62);
    send_key(FUNC_CHAR, KEY_BS);
    send_key(FUNC_CHAR, KEY_DEL);
    send_key(FUNC_CHAR, 8'h78);
    send_key(FUNC_CHAR, 8'h79);
    send_key(FUNC_CHAR, 8'h7A);
    send_key(FUNC_CHAR, KEY_KILL);
    // carriage return becomes newline at reset
    send_key(FUNC_CHAR, 8'h68);
    send_key(FUNC_CHAR, KEY_CR);
    send_key(FUNC_READ, 8'h00);
    send_key(FUNC_READ, 8'h00);
    send_key(FUNC_READ, 8'h00);
    // top byte value and end-of-file commit
    send_key(FUNC_CHAR, 8'hFF);
    send_key(FUNC_CHAR, KEY_EOF);
    send_key(FUNC_READ, 8'h00);
    send_key(FUNC_READ, 8'h00);
    // carriage return dropped
    write_cr_mode(1'b0);
    send_key(FUNC_CHAR, KEY_CR);
    send_key(FUNC_CHAR, 8'h71);
    send_key(FUNC_CHAR, KEY_NL);
    send_key(FUNC_READ, 8'h00);
    send_key(FUNC_READ, 8'h00);

    run_phase(80, 30, 1'b1, MIX_EDIT, 1'b0);
    // no reads: runs the buffer full, then drops bytes
    run_phase(180, 0, 1'b0, MIX_FILL, 1'b0);
    run_phase(100, 80, 1'b1, MIX_EDIT, 1'b0);
    run_phase(80, 35, 1'b0, MIX_EDIT, 1'b0);
    run_phase(80, 40, 1'b1, MIX_EDIT, 1'b1);
    run_phase(60, 40, 1'b0, MIX_RAW, 1'b0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
